// ----- hw/rtl/dedup_ready_queue_core_macros.svh -----
// ----------------------------------------------------------------------------
// dedup_ready_queue_core assertion macros
// clocked property shorthands for the checker file
// ----------------------------------------------------------------------------
`ifndef DEDUP_READY_QUEUE_CORE_MACROS_SVH
`define DEDUP_READY_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define DRQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/drq_pkg.sv -----
// ----------------------------------------------------------------------------
// drq_pkg
// shared types and codes of the dedup ready queue
// ----------------------------------------------------------------------------
package drq_pkg;

    localparam int CMD_W   = 2;
    localparam int KIND_W  = 2;
    localparam int FIELD_W = 32;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCHED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_HEAD,
        ST_RES
    } t_state;

endpackage

// ----- hw/rtl/dedup_ready_queue_core.sv -----
// ----------------------------------------------------------------------------
// dedup_ready_queue_core
// ready queue of (action, parameter) pairs with duplicate suppression
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel (tuser = cmd, tdata = action, param,
// status, value) and each gives exactly one result beat on m_axis
// (tuser = kind, tdata = head_action, head_param, out_status, out_value).
// Pairs live in one ram read one entry per cycle, so the time per command
// follows the occupancy n at acceptance:
//   add     scan, then append; finish reads the head entry,
//   remove  scan to the match, then shift the tail down,
//   empty-queue add or remove and unused codes go straight to the result.
// One command is in work at a time; s_axis_tready is high only while idle.
// A finished result sits in the output register, so a new command can be
// taken while m_axis waits; if the receiver stalls, the next result holds
// in the core until the output register drains.
// Reset empties the queue at once (occupancy to zero); ram contents are
// never read below the occupancy without having been written.
// ----------------------------------------------------------------------------
module dedup_ready_queue_core
    import drq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ACTION_BITS = 32,
    parameter int PARAM_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [4*FIELD_W-1:0] s_axis_tdata,  // action, param, status, value
    input  logic [CMD_W-1:0]     s_axis_tuser,  // cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [4*FIELD_W-1:0] m_axis_tdata,  // head_action, head_param,
                                                // out_status, out_value
    output logic [KIND_W-1:0]    m_axis_tuser   // kind
);

    localparam int SA = (ACTION_BITS < FIELD_W) ? ACTION_BITS : FIELD_W;
    localparam int SP = (PARAM_BITS < FIELD_W) ? PARAM_BITS : FIELD_W;
    localparam int WW = SA + SP;
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state               r_state, n_state;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_occ, n_occ;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [CMD_W-1:0]     r_cmd;
    logic [SA-1:0]        r_a;
    logic [SP-1:0]        r_p;
    logic [FIELD_W-1:0]   r_st;
    logic [FIELD_W-1:0]   r_val;
    logic [SA-1:0]        r_hd_a;
    logic [SP-1:0]        r_hd_p;
    logic                 r_m_valid;
    logic [KIND_W-1:0]    r_m_tuser;
    logic [4*FIELD_W-1:0] r_m_tdata;

    logic                 w_s_acc;
    logic                 w_out_free;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WW-1:0]        w_wdata;
    logic [WW-1:0]        w_rdata;
    logic [AW-1:0]        w_raddr;
    logic [SA-1:0]        w_rd_a;
    logic [SP-1:0]        w_rd_p;
    logic                 w_match;
    logic [CW-1:0]        w_idx_inc;
    logic [CW-1:0]        w_idx_dec;
    logic                 w_last;
    logic                 w_full;
    logic [4*FIELD_W-1:0] w_res_data;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    assign w_rd_a    = w_rdata[SA-1:0];
    assign w_rd_p    = w_rdata[WW-1:SA];
    assign w_match   = (w_rd_a == r_a) && (w_rd_p == r_p);
    assign w_idx_inc = r_idx + CW'(1);
    assign w_idx_dec = r_idx - CW'(1);
    assign w_last    = (w_idx_inc == r_occ);
    assign w_full    = (r_occ == CW'(QUEUE_DEPTH));
    assign w_raddr   = n_idx[AW-1:0];

    drq_ram #(
        .WIDTH (WW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    case (s_axis_tuser)
                        CMD_ADD, CMD_REMOVE: begin
                            n_state = (r_occ == '0) ? ST_RES : ST_SCAN;
                        end
                        CMD_FINISH: n_state = ST_HEAD;
                        default:    n_state = ST_RES;
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_match) begin
                    n_state = (r_cmd == CMD_REMOVE) ? ST_SHIFT : ST_RES;
                end else if (w_last) begin
                    n_state = ST_RES;
                end
            end
            ST_SHIFT: begin
                if (r_idx == r_occ) begin
                    n_state = ST_RES;
                end
            end
            ST_HEAD: n_state = ST_RES;
            ST_RES: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_idx   = r_idx;
        n_occ   = r_occ;
        n_kind  = r_kind;
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = {r_p, r_a};
        case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    n_idx  = '0;
                    n_kind = KIND_DONE;
                    if (s_axis_tuser == CMD_ADD && r_occ == '0) begin
                        w_we    = 1'b1;
                        w_waddr = '0;
                        w_wdata = {s_axis_tdata[FIELD_W +: SP], s_axis_tdata[SA-1:0]};
                        n_occ   = CW'(1);
                    end
                end
            end
            ST_SCAN: begin
                if (w_match) begin
                    if (r_cmd == CMD_REMOVE) begin
                        n_idx = w_idx_inc;
                    end
                end else if (w_last) begin
                    if (r_cmd == CMD_ADD) begin
                        if (w_full) begin
                            n_kind = KIND_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_occ[AW-1:0];
                            n_occ   = r_occ + CW'(1);
                        end
                    end
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            ST_SHIFT: begin
                if (r_idx == r_occ) begin
                    n_occ = r_occ - CW'(1);
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_idx_dec[AW-1:0];
                    w_wdata = w_rdata;
                    n_idx   = w_idx_inc;
                end
            end
            ST_HEAD: begin
                n_kind = (r_occ != '0) ? KIND_SCHED : KIND_IDLE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_res_data = '0;
        if (r_kind == KIND_SCHED) begin
            w_res_data[0 +: FIELD_W]       = FIELD_W'(r_hd_a);
            w_res_data[FIELD_W +: FIELD_W] = FIELD_W'(r_hd_p);
        end
        if (r_kind == KIND_SCHED || r_kind == KIND_IDLE) begin
            w_res_data[2*FIELD_W +: FIELD_W] = r_st;
            w_res_data[3*FIELD_W +: FIELD_W] = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_occ     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (r_state == ST_RES && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_kind <= n_kind;
        if (w_s_acc) begin
            r_cmd <= s_axis_tuser;
            r_a   <= s_axis_tdata[SA-1:0];
            r_p   <= s_axis_tdata[FIELD_W +: SP];
            r_st  <= s_axis_tdata[2*FIELD_W +: FIELD_W];
            r_val <= s_axis_tdata[3*FIELD_W +: FIELD_W];
        end
        if (r_state == ST_HEAD) begin
            r_hd_a <= w_rd_a;
            r_hd_p <= w_rd_p;
        end
        if (r_state == ST_RES && w_out_free) begin
            r_m_tuser <= r_kind;
            r_m_tdata <= w_res_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_tuser;
    assign m_axis_tdata  = r_m_tdata;

endmodule

// ----- hw/rtl/drq_ram.sv -----
// ----------------------------------------------------------------------------
// drq_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module drq_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/drq_checker.sv -----
// ----------------------------------------------------------------------------
// drq_checker
// port-level checks of the dedup ready queue, bound to the top level
// ----------------------------------------------------------------------------
`include "dedup_ready_queue_core_macros.svh"

module drq_checker
    import drq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [4*FIELD_W-1:0] i_m_tdata,
    input  logic [KIND_W-1:0]    i_m_tuser
);

    logic       w_s_acc;
    logic       w_m_acc;
    logic [1:0] r_outst;

    assign w_s_acc = i_s_tvalid && i_s_tready;
    assign w_m_acc = i_m_tvalid && i_m_tready;

    // commands taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + 2'(w_s_acc) - 2'(w_m_acc);
        end
    end

    `DRQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid, "result beat dropped while stalled")

    `DRQ_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, w_s_acc, !i_s_tready, "second command taken while one is in work")

    `DRQ_ASSERT_IMPL(a_no_phantom, i_clk, i_rst_n, i_m_tvalid, r_outst != 2'd0, "result beat without a command")

    `DRQ_ASSERT_IMPL(a_head_zero, i_clk, i_rst_n, i_m_tvalid && i_m_tuser != KIND_SCHED, i_m_tdata[2*FIELD_W-1:0] == '0, "head fields set outside a schedule result")

    `DRQ_ASSERT_IMPL(a_echo_zero, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser == KIND_DONE || i_m_tuser == KIND_FULL), i_m_tdata[4*FIELD_W-1:2*FIELD_W] == '0, "status or value set on an add or remove result")

endmodule

bind dedup_ready_queue_core drq_checker u_drq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

// ----- test/dedup_ready_queue_core_tb.sv -----
// ----------------------------------------------------------------------------
// dedup_ready_queue_core_tb
// self-checking bench for the dedup ready queue core
// ----------------------------------------------------------------------------
// Commands are sent on s_axis, and each accepted beat is run through a model
// of the queue in the bench. The model gives the one result beat that the
// command should produce. Result beats on m_axis are checked in order
// against these predictions. The run starts with directed cases and a
// fill-to-full pass. Then come random command mixes over a small pool of
// pairs, so that duplicate adds, matching removes and full drops happen
// often. Both sides insert random stalls, except in the final phase.
// ----------------------------------------------------------------------------
module dedup_ready_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drq_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] head_action;
        logic [FIELD_W-1:0] head_param;
        logic [FIELD_W-1:0] status;
        logic [FIELD_W-1:0] value;
    } result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [4*FIELD_W-1:0] s_axis_tdata = '0;  // action, param, status, value
    logic [CMD_W-1:0]     s_axis_tuser = '0;  // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [4*FIELD_W-1:0] m_axis_tdata;       // head_action, head_param,
                                              // out_status, out_value
    logic [KIND_W-1:0]    m_axis_tuser;       // kind

    logic [63:0] queued_pairs[$];     // {param, action}, head first
    result_t     pending_results[$];
    logic [63:0] pair_pool[POOL_SIZE];

    int  fail_count     = 0;
    int  cycle_count    = 0;
    int  items_accepted = 0;
    int  kind_seen[4]   = '{0, 0, 0, 0};
    int  sink_hold      = 0;
    bit  src_idle_en    = 1'b1;
    bit  snk_idle_en    = 1'b1;

    dedup_ready_queue_core #(
        .QUEUE_DEPTH (QDEPTH),
        .ACTION_BITS (32),
        .PARAM_BITS  (32)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic result_t step_ready_queue(input logic [CMD_W-1:0] cmd,
                                                 input logic [4*FIELD_W-1:0] beat);
        logic [63:0] pair;
        int          hit;
        result_t     res;
        pair = beat[63:0];
        hit  = -1;
        res  = '0;
        res.kind = KIND_DONE;
        foreach (queued_pairs[i])
            if (hit < 0 && queued_pairs[i] == pair)
                hit = i;
        case (cmd)
            CMD_ADD: begin
                if (hit < 0) begin
                    if (queued_pairs.size() >= QDEPTH)
                        res.kind = KIND_FULL;
                    else
                        queued_pairs.push_back(pair);
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0)
                    queued_pairs.delete(hit);
            end
            CMD_FINISH: begin
                if (queued_pairs.size() > 0) begin
                    res.kind        = KIND_SCHED;
                    res.head_action = queued_pairs[0][31:0];
                    res.head_param  = queued_pairs[0][63:32];
                end else begin
                    res.kind = KIND_IDLE;
                end
                res.status = beat[95:64];
                res.value  = beat[127:96];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 20)
            $display("mismatch at cycle %0d: %s got %h expected %h",
                     cycle_count, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : result_monitor
        result_t got;
        result_t want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = step_ready_queue(s_axis_tuser, s_axis_tdata);
                pending_results.push_back(want);
                kind_seen[want.kind]++;
                items_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind        = m_axis_tuser;
                got.head_action = m_axis_tdata[31:0];
                got.head_param  = m_axis_tdata[63:32];
                got.status      = m_axis_tdata[95:64];
                got.value       = m_axis_tdata[127:96];
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat, kind", got.kind, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("kind", got.kind, want.kind);
                    if (got.head_action !== want.head_action)
                        report_mismatch("head_action", got.head_action, want.head_action);
                    if (got.head_param !== want.head_param)
                        report_mismatch("head_param", got.head_param, want.head_param);
                    if (got.status !== want.status)
                        report_mismatch("out_status", got.status, want.status);
                    if (got.value !== want.value)
                        report_mismatch("out_value", got.value, want.value);
                end
            end
        end
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold--;
            if (sink_hold == 0)
                m_axis_tready <= 1'b1;
        end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(1, 17);
            m_axis_tready <= 1'b0;
        end
    end

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [31:0] act,
                             input logic [31:0] par, input logic [31:0] st,
                             input logic [31:0] val);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, st, par, act};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic send_random_item(input int add_pct);
        int            r;
        logic [CMD_W-1:0] cmd;
        logic [63:0]   pair;
        logic [31:0]   st;
        r = $urandom_range(0, 99);
        if (r < 3)
            cmd = CMD_UNUSED;
        else if (r < 3 + add_pct)
            cmd = CMD_ADD;
        else if (r < 3 + add_pct + (97 - add_pct) * 2 / 3)
            cmd = CMD_REMOVE;
        else
            cmd = CMD_FINISH;
        if ($urandom_range(0, 9) < 8) begin
            pair = pair_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            pair = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0)
                pair_pool[$urandom_range(4, POOL_SIZE - 1)] = pair;
        end
        case ($urandom_range(0, 9))
            0:       st = 32'h8000_0000;
            1:       st = 32'h7fff_ffff;
            default: st = $urandom;
        endcase
        send_beat(cmd, pair[31:0], pair[63:32], st, $urandom);
    endtask

    task automatic test_directed();
        send_beat(CMD_FINISH, 32'h0, 32'h0, 32'h8000_0000, 32'hffff_ffff);
        send_beat(CMD_REMOVE, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0);
        send_beat(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(CMD_ADD, 32'h0, 32'h0, 32'h0, 32'h0);
        send_beat(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0);
        // duplicate add
        send_beat(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h1234_5678, 32'h9abc_def0);
        send_beat(CMD_ADD, 32'h0, 32'hffff_ffff, 32'h0, 32'h0);
        send_beat(CMD_FINISH, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0);
        // remove with no match
        send_beat(CMD_REMOVE, 32'hffff_ffff, 32'h0, 32'h0, 32'h0);
        send_beat(CMD_REMOVE, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0);
        send_beat(CMD_FINISH, 32'h0, 32'h0, 32'hffff_ffff, 32'h0000_0001);
        send_beat(CMD_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0);
        send_beat(CMD_FINISH, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'hffff_ffff);
        send_beat(CMD_REMOVE, 32'h0, 32'hffff_ffff, 32'h0, 32'h0);
        send_beat(CMD_FINISH, 32'h0, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic test_full_queue();
        logic [63:0] filled[QDEPTH];
        int          idx;
        for (int i = 0; i < QDEPTH; i++) begin
            filled[i] = {$urandom, $urandom};
            send_beat(CMD_ADD, filled[i][31:0], filled[i][63:32], $urandom, $urandom);
        end
        pause_until_drained();
        send_beat(CMD_ADD, $urandom, $urandom, $urandom, $urandom);
        send_beat(CMD_ADD, filled[5][31:0], filled[5][63:32], 32'h0, 32'h0);
        send_beat(CMD_FINISH, $urandom, $urandom, $urandom, $urandom);
        // stride 7 visits head, middle and tail entries
        for (int k = 0; k < QDEPTH; k++) begin
            idx = (k * 7) % QDEPTH;
            send_beat(CMD_REMOVE, filled[idx][31:0], filled[idx][63:32], $urandom, $urandom);
        end
        send_beat(CMD_FINISH, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_random_mix(input int count, input int add_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) == 0)
                pause_until_drained();
            send_random_item(add_pct);
        end
    endtask

    task automatic test_back_to_back(input int count);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        for (int i = 0; i < count; i++)
            send_random_item((i / 50) % 2 == 0 ? 55 : 30);
    endtask

    initial begin
        pair_pool[0] = 64'h0;
        pair_pool[1] = 64'hffff_ffff_ffff_ffff;
        pair_pool[2] = 64'hffff_ffff_0000_0000;
        pair_pool[3] = 64'h0000_0000_ffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
            pair_pool[i] = {$urandom, $urandom};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_queue();
        test_random_mix(275, 60);
        test_random_mix(275, 30);
        test_back_to_back(350);

        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        repeat (40) @(posedge i_clk);

        $display("%0d commands checked: %0d head schedules, %0d idle finishes,",
                 items_accepted, kind_seen[KIND_SCHED], kind_seen[KIND_IDLE]);
        $display("%0d adds dropped on a full queue, %0d plain done results",
                 kind_seen[KIND_FULL], kind_seen[KIND_DONE]);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
